// ===== hw/rtl/cab_pkg.sv =====
// ----------------------------------------------------------------------------
// cab_pkg: shared definitions for the clipped alpha blit
// Register indexes, reset values, size limits and the flag struct.
// ----------------------------------------------------------------------------
`default_nettype none

package cab_pkg;

  // Configuration register width and index width
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y         = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0] SPRITE_WIDTH_RST  = 13'd64;
  localparam logic [CFG_W-1:0] SPRITE_HEIGHT_RST = 13'd64;
  localparam logic [CFG_W-1:0] POS_RST           = 13'd0;

  // Default size limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Pixel formats
  localparam int CHAN_W = 8;
  localparam int ADDR_W = 24;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

  // Per-pixel write decision, clip stage to blend stage
  typedef struct packed {
    logic in_clip;
    logic write_enable;
    logic write_alpha;
  } clip_t;

  // Sprite counter status
  typedef struct packed {
    logic last_col;
    logic last_row;
  } cnt_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cab_pixel_if.sv =====
// ----------------------------------------------------------------------------
// cab_pixel_if: input pixel channel
// Sprite RGBA plus framebuffer RGB for one pixel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cab_pixel_if
  import cab_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] src_red;
  logic [CHAN_W-1:0] src_green;
  logic [CHAN_W-1:0] src_blue;
  logic [CHAN_W-1:0] src_alpha;
  logic [CHAN_W-1:0] dst_red;
  logic [CHAN_W-1:0] dst_green;
  logic [CHAN_W-1:0] dst_blue;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue,
    input  ready
  );

  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/cab_result_if.sv =====
// ----------------------------------------------------------------------------
// cab_result_if: output result channel
// Screen address, color and write flags for one pixel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cab_result_if
  import cab_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] pixel_address;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              write_enable;
  logic              write_alpha;
  logic              last_pixel;

  modport source (
    output valid, pixel_address, out_red, out_green, out_blue,
           write_enable, write_alpha, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_address, out_red, out_green, out_blue,
           write_enable, write_alpha, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/cab_counter.sv =====
// ----------------------------------------------------------------------------
// cab_counter: sprite raster counters
// Column and row counters that advance once per accepted item and wrap at
// the clamped sprite size.
// ----------------------------------------------------------------------------
`default_nettype none

module cab_counter
  import cab_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic [CFG_W-1:0]              sprite_width,
  input  wire logic [CFG_W-1:0]              sprite_height,
  output logic [$clog2(MAX_WIDTH)-1:0]       col,
  output logic [$clog2(MAX_HEIGHT)-1:0]      row,
  output cnt_status_t                        status
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int ZW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int ZH = (CFG_W > RW + 1) ? CFG_W : RW + 1;

  logic [ZW-1:0] pw;
  logic [ZH-1:0] ph;
  logic [ZW-1:0] pw_ext;
  logic [ZH-1:0] ph_ext;

  // Sprite size clamped to [1, max]
  always_comb begin
    pw_ext = ZW'(sprite_width);
    ph_ext = ZH'(sprite_height);
    if (pw_ext == '0) begin
      pw = ZW'(1);
    end else if (pw_ext > ZW'(MAX_WIDTH)) begin
      pw = ZW'(MAX_WIDTH);
    end else begin
      pw = pw_ext;
    end
    if (ph_ext == '0) begin
      ph = ZH'(1);
    end else if (ph_ext > ZH'(MAX_HEIGHT)) begin
      ph = ZH'(MAX_HEIGHT);
    end else begin
      ph = ph_ext;
    end
  end

  // At or past the last value counts as last (size may shrink mid-sprite)
  assign status.last_col = ZW'(col) >= (pw - ZW'(1));
  assign status.last_row = ZH'(row) >= (ph - ZH'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (status.last_col) begin
        col <= '0;
        row <= status.last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Column wraps after the last column
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    advance && status.last_col |=> col == '0)
    else $error("column did not wrap");

  // Row holds while the column is mid-row
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    advance && !status.last_col |=> row == $past(row) && col == $past(col) + CW'(1))
    else $error("counter stepped wrongly mid-row");

  // Both counters wrap after the final pixel
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    advance && status.last_col && status.last_row |=> row == '0 && col == '0)
    else $error("row did not wrap");

endmodule

`default_nettype wire

// ===== hw/rtl/cab_clip.sv =====
// ----------------------------------------------------------------------------
// cab_clip: screen clip and address
// Places the sprite pixel on the screen, tests it against the screen
// rectangle and forms the linear framebuffer address.
// ----------------------------------------------------------------------------
`default_nettype none

module cab_clip
  import cab_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic [CFG_W-1:0]              screen_width,
  input  wire logic [CFG_W-1:0]              screen_height,
  input  wire logic signed [CFG_W-1:0]       pos_x,
  input  wire logic signed [CFG_W-1:0]       pos_y,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  col,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0] row,
  input  wire logic [CHAN_W-1:0]             alpha,
  output clip_t                              flags,
  output logic [ADDR_W-1:0]                  addr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int ZW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int ZH = (CFG_W > RW + 1) ? CFG_W : RW + 1;
  localparam int PW = ZW + ZH;

  logic signed [ZW:0] x;
  logic signed [ZH:0] y;
  logic [ZW-1:0]      sw;
  logic [ZH-1:0]      sh;
  logic [ZW-1:0]      sw_ext;
  logic [ZH-1:0]      sh_ext;
  logic [PW-1:0]      row_base;

  // Screen size saturated to the maximum
  always_comb begin
    sw_ext = ZW'(screen_width);
    sh_ext = ZH'(screen_height);
    sw = (sw_ext > ZW'(MAX_WIDTH))  ? ZW'(MAX_WIDTH)  : sw_ext;
    sh = (sh_ext > ZH'(MAX_HEIGHT)) ? ZH'(MAX_HEIGHT) : sh_ext;
  end

  // Screen coordinate, one bit wider than any magnitude for the sign
  assign x = (ZW + 1)'(pos_x) + $signed({1'b0, ZW'(col)});
  assign y = (ZH + 1)'(pos_y) + $signed({1'b0, ZH'(row)});

  always_comb begin
    flags.in_clip      = !x[ZW] && !y[ZH] && (x[ZW-1:0] < sw) && (y[ZH-1:0] < sh);
    flags.write_enable = flags.in_clip && (alpha != '0);
    flags.write_alpha  = flags.write_enable && (alpha == ALPHA_OPAQUE);
  end

  // Linear address, masked to the address width
  assign row_base = PW'(y[ZH-1:0]) * PW'(sw);

  always_comb begin
    if (flags.in_clip) begin
      addr = ADDR_W'(row_base + PW'(x[ZW-1:0]));
    end else begin
      addr = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cab_blend.sv =====
// ----------------------------------------------------------------------------
// cab_blend: one color channel
// Keeps dest, copies source or blends dest + (alpha*(src-dest)) >>> 8.
// ----------------------------------------------------------------------------
`default_nettype none

module cab_blend
  import cab_pkg::*;
(
  input  wire logic [CHAN_W-1:0] src,
  input  wire logic [CHAN_W-1:0] dst,
  input  wire logic [CHAN_W-1:0] alpha,
  input  wire clip_t             flags,
  output logic [CHAN_W-1:0]      result
);

  logic signed [CHAN_W:0]       diff;
  logic signed [2*CHAN_W+1:0]   prod;
  logic signed [2*CHAN_W+1:0]   quot;
  logic [CHAN_W-1:0]            mixed;

  // Signed difference times alpha, floor division by 256
  assign diff  = $signed({1'b0, src}) - $signed({1'b0, dst});
  assign prod  = $signed({1'b0, alpha}) * diff;
  assign quot  = prod >>> CHAN_W;
  assign mixed = dst + quot[CHAN_W-1:0];

  always_comb begin
    if (!flags.write_enable) begin
      result = dst;
    end else if (flags.write_alpha) begin
      result = src;
    end else begin
      result = mixed;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/clipped_alpha_blit_top.sv =====
// ----------------------------------------------------------------------------
// clipped_alpha_blit_top: clipped alpha blit of a sprite onto a framebuffer
// Stages: input register, then clip/address/blend logic into the result
//   register.
// Throughput: one item per cycle; both stages move whenever the result
//   register is empty or being taken.
// Reset: clears counters, stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_alpha_blit_top
  import cab_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  cab_pixel_if.sink                 pixel,
  cab_result_if.source              result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Configuration registers
  logic [CFG_W-1:0]        screen_width;
  logic [CFG_W-1:0]        screen_height;
  logic [CFG_W-1:0]        sprite_width;
  logic [CFG_W-1:0]        sprite_height;
  logic signed [CFG_W-1:0] pos_x;
  logic signed [CFG_W-1:0] pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      sprite_width  <= SPRITE_WIDTH_RST;
      sprite_height <= SPRITE_HEIGHT_RST;
      pos_x         <= POS_RST;
      pos_y         <= POS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        CFG_SPRITE_WIDTH:  sprite_width  <= cfg_data;
        CFG_SPRITE_HEIGHT: sprite_height <= cfg_data;
        CFG_POS_X:         pos_x         <= cfg_data;
        CFG_POS_Y:         pos_y         <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Handshake
  logic s1_valid;
  logic out_valid;
  logic advance;
  logic accept;

  assign advance     = !out_valid || result.ready;
  assign pixel.ready = !s1_valid || advance;
  assign accept      = pixel.valid && pixel.ready;

  // Sprite counters
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  cnt_status_t   status;

  cab_counter #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_counter (
    .clk           (clk),
    .rst           (rst),
    .advance       (accept),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .col           (col),
    .row           (row),
    .status        (status)
  );

  // Input register: item plus counter snapshot
  logic [CHAN_W-1:0] s1_src_red, s1_src_green, s1_src_blue, s1_src_alpha;
  logic [CHAN_W-1:0] s1_dst_red, s1_dst_green, s1_dst_blue;
  logic [CW-1:0]     s1_col;
  logic [RW-1:0]     s1_row;
  logic              s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
    if (accept) begin
      s1_src_red   <= pixel.src_red;
      s1_src_green <= pixel.src_green;
      s1_src_blue  <= pixel.src_blue;
      s1_src_alpha <= pixel.src_alpha;
      s1_dst_red   <= pixel.dst_red;
      s1_dst_green <= pixel.dst_green;
      s1_dst_blue  <= pixel.dst_blue;
      s1_col       <= col;
      s1_row       <= row;
      s1_last      <= status.last_col && status.last_row;
    end
  end

  // Clip and address
  clip_t             flags;
  logic [ADDR_W-1:0] addr_next;

  cab_clip #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_clip (
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .col           (s1_col),
    .row           (s1_row),
    .alpha         (s1_src_alpha),
    .flags         (flags),
    .addr          (addr_next)
  );

  // Per-channel blend
  logic [CHAN_W-1:0] red_next, green_next, blue_next;

  cab_blend u_blend_red (
    .src (s1_src_red), .dst (s1_dst_red), .alpha (s1_src_alpha),
    .flags (flags), .result (red_next)
  );

  cab_blend u_blend_green (
    .src (s1_src_green), .dst (s1_dst_green), .alpha (s1_src_alpha),
    .flags (flags), .result (green_next)
  );

  cab_blend u_blend_blue (
    .src (s1_src_blue), .dst (s1_dst_blue), .alpha (s1_src_alpha),
    .flags (flags), .result (blue_next)
  );

  // Result register
  logic [ADDR_W-1:0] out_address;
  logic [CHAN_W-1:0] out_red, out_green, out_blue;
  logic              out_we, out_wa, out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      out_address <= addr_next;
      out_red     <= red_next;
      out_green   <= green_next;
      out_blue    <= blue_next;
      out_we      <= flags.write_enable;
      out_wa      <= flags.write_alpha;
      out_last    <= s1_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.pixel_address = out_address;
  assign result.out_red       = out_red;
  assign result.out_green     = out_green;
  assign result.out_blue      = out_blue;
  assign result.write_enable  = out_we;
  assign result.write_alpha   = out_wa;
  assign result.last_pixel    = out_last;

  // Alpha byte is only written along with the color
  a_wa_needs_we: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_wa |-> out_we)
    else $error("write_alpha without write_enable");

  // Full pipe with a stalled output takes no new item
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |-> !pixel.ready)
    else $error("item accepted into a full pipe");

  // A held item in the input register is not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input register item lost");

endmodule

`default_nettype wire
